// ===== hdl/ppcd_pkg.sv =====
// ppcd_pkg: shared widths, angle constants, command codes, sideband type and
// arctangent table for the planar pose compose/difference pipeline
// no dependencies
package ppcd_pkg;

  localparam int ROTATION_STEPS_DEF  = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int TABLE_LEN           = 24;

  localparam int POS_W  = 32;
  localparam int HEAD_W = 21;
  localparam int ANG_W  = 22;
  localparam int OP_W   = 33;
  localparam int CW     = 34;
  localparam int HR_W   = 35;
  localparam int TRIG_W = 30;
  localparam int PROD_W = 63;
  localparam int SUM_W  = 64;
  localparam int RND_SH = 28;
  localparam int RSUM_W = SUM_W - RND_SH + 1;

  localparam int HEAD_RECIP_SH = 24;
  localparam int ANG_RECIP_SH  = 28;

  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint TWO_PI_Q30   = 64'sd6746518852;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint INV_GAIN_Q30 = 64'sd652032874;

  localparam logic CMD_COMPOSE  = 1'b0;
  localparam logic CMD_RELATIVE = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [POS_W-1:0]   add_x;
    logic signed [POS_W-1:0]   add_y;
    logic signed [OP_W-1:0]    op_a;
    logic signed [OP_W-1:0]    op_b;
    logic        [ANG_W-1:0]   ang;
    logic                      neg;
  } side_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd843314857;
      1:       v = 32'd497837829;
      2:       v = 32'd263043837;
      3:       v = 32'd133525159;
      4:       v = 32'd67021687;
      5:       v = 32'd33543516;
      6:       v = 32'd16775851;
      7:       v = 32'd8388437;
      8:       v = 32'd4194283;
      9:       v = 32'd2097149;
      10:      v = 32'd1048576;
      11:      v = 32'd524288;
      12:      v = 32'd262144;
      13:      v = 32'd131072;
      14:      v = 32'd65536;
      15:      v = 32'd32768;
      16:      v = 32'd16384;
      17:      v = 32'd8192;
      18:      v = 32'd4096;
      19:      v = 32'd2048;
      20:      v = 32'd1024;
      21:      v = 32'd512;
      22:      v = 32'd256;
      23:      v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/planar_pose_compose_and_difference.sv =====
// planar_pose_compose_and_difference: fully pipelined se(2) pose compose and
// relative motion; the path from the accepting edge to done runs through stages
// 1-5 (select, reduction, fold), the cordic stages, stages 6-8 (round, multiply,
// sum) and the output register; throughput one item per cycle, busy is high only in reset
// rst clears all valid bits; depends on ppcd_pkg and ppcd_cordic
module planar_pose_compose_and_difference
  import ppcd_pkg::*;
#(
  parameter int ROTATION_STEPS  = ROTATION_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command,
  input  logic signed [POS_W-1:0]  base_x,
  input  logic signed [POS_W-1:0]  base_y,
  input  logic signed [HEAD_W-1:0] base_heading,
  input  logic signed [POS_W-1:0]  arg_first,
  input  logic signed [POS_W-1:0]  arg_second,
  input  logic signed [HEAD_W-1:0] arg_angle,
  output logic                     done,
  output logic signed [POS_W-1:0]  res_first,
  output logic signed [POS_W-1:0]  res_second,
  output logic signed [ANG_W-1:0]  res_angle
);

  localparam int F     = ANGLE_FRAC_BITS;
  localparam int SH    = 30 - F;
  localparam int NST   = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
  localparam int LAT   = NST + 9;
  localparam int TW    = (53 - F > 37) ? 53 - F : 37;
  localparam int KW    = 23 - F;
  localparam int AW    = (F + 6 > 24) ? F + 6 : 24;
  localparam int HPRW  = HEAD_RECIP_SH + KW + 1;
  localparam int APRW  = ANG_RECIP_SH + KW + 1;
  localparam longint HM  = (64'sd1 <<< (HEAD_RECIP_SH + SH)) / TWO_PI_Q30;
  localparam longint TWV = (TWO_PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam longint AM  = (64'sd1 <<< ANG_RECIP_SH) / TWV;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [RSUM_W-1:0] r);
    logic signed [POS_W-1:0] v;
    if ((&r[RSUM_W-1:POS_W-1]) || !(|r[RSUM_W-1:POS_W-1])) begin
      v = r[POS_W-1:0];
    end else if (r[RSUM_W-1]) begin
      v = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      v = {1'b0, {(POS_W-1){1'b1}}};
    end
    return v;
  endfunction

  logic accept;
  assign busy   = rst;
  assign accept = start && !busy;

  // stage 1: operand select, angle sum, reciprocal products
  logic                     s1_valid;
  side_t                    s1_side, s1_side_next;
  logic signed [HEAD_W-1:0] s1_head;
  logic signed [ANG_W-1:0]  s1_asum, s1_asum_next;
  logic signed [HPRW-1:0]   s1_hprod;
  logic signed [APRW-1:0]   s1_aprod;

  always_comb begin
    s1_side_next.cmd = command;
    if (command == CMD_RELATIVE) begin
      s1_asum_next       = ANG_W'(arg_angle) - ANG_W'(base_heading);
      s1_side_next.add_x = '0;
      s1_side_next.add_y = '0;
      s1_side_next.op_a  = OP_W'(arg_first) - OP_W'(base_x);
      s1_side_next.op_b  = OP_W'(arg_second) - OP_W'(base_y);
    end else begin
      s1_asum_next       = ANG_W'(arg_angle) + ANG_W'(base_heading);
      s1_side_next.add_x = base_x;
      s1_side_next.add_y = base_y;
      s1_side_next.op_a  = OP_W'(arg_first);
      s1_side_next.op_b  = OP_W'(arg_second);
    end
    s1_side_next.ang = '0;
    s1_side_next.neg = 1'b0;
  end

  always_ff @(posedge clk) begin
    s1_side  <= s1_side_next;
    s1_head  <= base_heading;
    s1_asum  <= s1_asum_next;
    s1_hprod <= HPRW'(base_heading) * HPRW'(HM);
    s1_aprod <= APRW'(s1_asum_next) * APRW'(AM);
  end

  // stage 2: quotient estimates times the wrap constants
  logic                     s2_valid;
  side_t                    s2_side;
  logic signed [HEAD_W-1:0] s2_head;
  logic signed [ANG_W-1:0]  s2_asum;
  logic signed [TW-1:0]     s2_kt;
  logic signed [AW-1:0]     s2_akt;
  logic signed [KW-1:0]     hk, ak;

  assign hk = KW'(s1_hprod >>> HEAD_RECIP_SH);
  assign ak = KW'(s1_aprod >>> ANG_RECIP_SH);

  always_ff @(posedge clk) begin
    s2_side <= s1_side;
    s2_head <= s1_head;
    s2_asum <= s1_asum;
    s2_kt   <= TW'(hk) * TW'(TWO_PI_Q30);
    s2_akt  <= AW'(ak) * AW'(TWV);
  end

  // stage 3: remainders
  logic                     s3_valid;
  side_t                    s3_side;
  logic signed [ANG_W-1:0]  s3_asum;
  logic signed [TW-1:0]     s3_rem, t_full;
  logic signed [AW-1:0]     s3_arem;

  assign t_full = TW'(s2_head) <<< SH;

  always_ff @(posedge clk) begin
    s3_side <= s2_side;
    s3_asum <= s2_asum;
    s3_rem  <= t_full - s2_kt;
    s3_arem <= AW'(s2_asum) - s2_akt;
  end

  // stage 4: one correction step each way
  logic                     s4_valid;
  side_t                    s4_side, s4_side_next;
  logic signed [HR_W-1:0]   s4_t;
  logic signed [TW-1:0]     h_corr;
  logic signed [AW-1:0]     a_corr;

  always_comb begin
    if (s3_rem < 0) begin
      h_corr = s3_rem + TW'(TWO_PI_Q30);
    end else if (s3_rem >= TW'(TWO_PI_Q30)) begin
      h_corr = s3_rem - TW'(TWO_PI_Q30);
    end else begin
      h_corr = s3_rem;
    end
    if (s3_arem < 0) begin
      a_corr = s3_arem + AW'(TWV);
    end else if (s3_arem >= AW'(TWV)) begin
      a_corr = s3_arem - AW'(TWV);
    end else begin
      a_corr = s3_arem;
    end
    s4_side_next = s3_side;
    if (s3_side.cmd == CMD_RELATIVE) begin
      s4_side_next.ang = s3_asum;
    end else begin
      s4_side_next.ang = a_corr[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    s4_side <= s4_side_next;
    s4_t    <= HR_W'(h_corr);
  end

  // stage 5: fold into [-pi/2, pi/2]
  logic                     s5_valid;
  side_t                    s5_side, s5_side_next;
  logic signed [CW-1:0]     s5_z, s5_z_next;

  always_comb begin
    s5_side_next = s4_side;
    if (s4_t <= HR_W'(HALF_PI_Q30)) begin
      s5_z_next        = CW'(s4_t);
      s5_side_next.neg = 1'b0;
    end else if (s4_t < HR_W'(TWO_PI_Q30 - HALF_PI_Q30)) begin
      s5_z_next        = CW'(s4_t - HR_W'(PI_Q30));
      s5_side_next.neg = 1'b1;
    end else begin
      s5_z_next        = CW'(s4_t - HR_W'(TWO_PI_Q30));
      s5_side_next.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s5_side <= s5_side_next;
    s5_z    <= s5_z_next;
  end

  logic                 cr_valid;
  logic signed [CW-1:0] cr_x, cr_y;
  side_t                cr_side;

  ppcd_cordic #(
    .STEPS (ROTATION_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s5_valid),
    .in_z      (s5_z),
    .in_side   (s5_side),
    .out_valid (cr_valid),
    .out_x     (cr_x),
    .out_y     (cr_y),
    .out_side  (cr_side)
  );

  // stage 6: round to q28 and apply fold sign
  logic                     s6_valid;
  side_t                    s6_side;
  logic signed [TRIG_W-1:0] s6_c, s6_s;
  logic signed [CW-1:0]     c_rnd, s_rnd;

  assign c_rnd = (cr_x + CW'(2)) >>> 2;
  assign s_rnd = (cr_y + CW'(2)) >>> 2;

  always_ff @(posedge clk) begin
    s6_side <= cr_side;
    s6_c    <= TRIG_W'(cr_side.neg ? -c_rnd : c_rnd);
    s6_s    <= TRIG_W'(cr_side.neg ? -s_rnd : s_rnd);
  end

  // stage 7: four products
  logic                     s7_valid;
  side_t                    s7_side;
  logic signed [PROD_W-1:0] s7_ac, s7_as, s7_bc, s7_bs;

  always_ff @(posedge clk) begin
    s7_side <= s6_side;
    s7_ac   <= PROD_W'(s6_side.op_a) * PROD_W'(s6_c);
    s7_as   <= PROD_W'(s6_side.op_a) * PROD_W'(s6_s);
    s7_bc   <= PROD_W'(s6_side.op_b) * PROD_W'(s6_c);
    s7_bs   <= PROD_W'(s6_side.op_b) * PROD_W'(s6_s);
  end

  // stage 8: sums with half-up rounding
  logic                     s8_valid;
  side_t                    s8_side;
  logic signed [RSUM_W-1:0] s8_p, s8_q;
  logic signed [SUM_W-1:0]  p_sum, q_sum;

  always_comb begin
    if (s7_side.cmd == CMD_RELATIVE) begin
      p_sum = SUM_W'(s7_ac) + SUM_W'(s7_bs);
      q_sum = SUM_W'(s7_bc) - SUM_W'(s7_as);
    end else begin
      p_sum = SUM_W'(s7_ac) - SUM_W'(s7_bs);
      q_sum = SUM_W'(s7_as) + SUM_W'(s7_bc);
    end
  end

  always_ff @(posedge clk) begin
    s8_side <= s7_side;
    s8_p    <= RSUM_W'((p_sum + (SUM_W'(1) <<< (RND_SH - 1))) >>> RND_SH);
    s8_q    <= RSUM_W'((q_sum + (SUM_W'(1) <<< (RND_SH - 1))) >>> RND_SH);
  end

  // output stage: base add and saturation
  always_ff @(posedge clk) begin
    res_first  <= sat32(RSUM_W'(s8_side.add_x) + s8_p);
    res_second <= sat32(RSUM_W'(s8_side.add_y) + s8_q);
    res_angle  <= s8_side.ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= cr_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      done     <= s8_valid;
    end
  end

  // every result traces back to an item taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without matching item");

  // reduced heading lies in [0, 2pi)
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (s4_t >= 0 && s4_t < HR_W'(TWO_PI_Q30)))
    else $error("heading reduction out of range");

  // folded angle lies in [-pi/2, pi/2]
  a_folded: assert property (@(posedge clk) disable iff (rst)
    s5_valid |-> (s5_z <= CW'(HALF_PI_Q30) && s5_z >= -CW'(HALF_PI_Q30)))
    else $error("folded angle out of range");

endmodule

// ===== hdl/ppcd_cordic.sv =====
// ppcd_cordic: pipelined rotation-mode cordic, one iteration per register stage,
// carries the item sideband alongside the vector
// depends on ppcd_pkg
module ppcd_cordic
  import ppcd_pkg::*;
#(
  parameter int STEPS = ROTATION_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] in_z,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_x,
  output logic signed [CW-1:0] out_y,
  output side_t                out_side
);

  localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

  logic                 vr [N];
  logic signed [CW-1:0] xr [N];
  logic signed [CW-1:0] yr [N];
  logic signed [CW-1:0] zr [N-1];
  side_t                sr [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [CW-1:0] AT = CW'(atan_q30(i));
    logic                 vi;
    logic signed [CW-1:0] xi, yi, zi, xn, yn;
    side_t                si;

    if (i == 0) begin : g_src
      assign vi = in_valid;
      assign xi = CW'(INV_GAIN_Q30);
      assign yi = '0;
      assign zi = in_z;
      assign si = in_side;
    end else begin : g_src
      assign vi = vr[i-1];
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
      assign si = sr[i-1];
    end

    always_comb begin
      if (zi >= 0) begin
        xn = xi - (yi >>> i);
        yn = yi + (xi >>> i);
      end else begin
        xn = xi + (yi >>> i);
        yn = yi - (xi >>> i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i] <= 1'b0;
      end else begin
        vr[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      xr[i] <= xn;
      yr[i] <= yn;
      sr[i] <= si;
    end

    if (i < N - 1) begin : g_z
      logic signed [CW-1:0] zn;
      assign zn = (zi >= 0) ? (zi - AT) : (zi + AT);
      always_ff @(posedge clk) begin
        zr[i] <= zn;
      end
    end
  end

  assign out_valid = vr[N-1];
  assign out_x     = xr[N-1];
  assign out_y     = yr[N-1];
  assign out_side  = sr[N-1];

endmodule

// ===== test/planar_pose_checker.sv =====
// planar_pose_checker: watches the item and result ports of the planar pose
// compose/difference block, predicts each result and compares it field by field
// depends on ppcd_pkg for widths, angle constants and command codes
`timescale 1ns / 1ps

module planar_pose_checker
  import ppcd_pkg::*;
#(
  parameter int ROTATION_STEPS  = ROTATION_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     command,
  input  logic signed [POS_W-1:0]  base_x,
  input  logic signed [POS_W-1:0]  base_y,
  input  logic signed [HEAD_W-1:0] base_heading,
  input  logic signed [POS_W-1:0]  arg_first,
  input  logic signed [POS_W-1:0]  arg_second,
  input  logic signed [HEAD_W-1:0] arg_angle,
  input  logic                     done,
  input  logic signed [POS_W-1:0]  res_first,
  input  logic signed [POS_W-1:0]  res_second,
  input  logic signed [ANG_W-1:0]  res_angle,
  output int                       failures,
  output int                       outstanding
);

  localparam int ITERS = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;

  localparam longint ATAN_STEP [0:23] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  typedef struct packed {
    logic signed [POS_W-1:0] first;
    logic signed [POS_W-1:0] second;
    logic        [ANG_W-1:0] angle;
  } pose_result_t;

  pose_result_t expected_poses[$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  task automatic report(input string what);
    failures++;
    if (failures <= 200) $display("mismatch: %s", what);
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cosine and sine of a heading, Q.28
  function automatic void heading_trig(input longint heading, output longint cs,
                                       output longint sn);
    longint t, x, y, nx;
    logic   flip;
    t    = heading <<< (30 - ANGLE_FRAC_BITS);
    x    = INV_GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    t = t % TWO_PI_Q30;
    if (t < 0) t = t + TWO_PI_Q30;
    if (t > PI_Q30) t = t - TWO_PI_Q30;
    if (t > HALF_PI_Q30) begin
      t    = t - PI_Q30;
      flip = 1'b1;
    end else if (t < -HALF_PI_Q30) begin
      t    = t + PI_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        t  = t - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        t  = t + ATAN_STEP[i];
      end
      x = nx;
    end
    x  = (x + 64'sd2) >>> 2;
    y  = (y + 64'sd2) >>> 2;
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic pose_result_t compose_or_diff(
    input logic   cmd,
    input longint bx, input longint by, input longint bh,
    input longint a1, input longint a2, input longint aa);
    pose_result_t r;
    longint cs, sn, p, q, dx, dy, ang, wrap;
    longint half;
    half = 64'sd1 <<< 27;
    heading_trig(bh, cs, sn);
    if (cmd == CMD_COMPOSE) begin
      wrap = (TWO_PI_Q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
      p = a1 * cs - a2 * sn;
      q = a1 * sn + a2 * cs;
      r.first  = POS_W'(clamp32(bx + ((p + half) >>> 28)));
      r.second = POS_W'(clamp32(by + ((q + half) >>> 28)));
      ang = (bh + aa) % wrap;
      if (ang < 0) ang = ang + wrap;
    end else begin
      dx = a1 - bx;
      dy = a2 - by;
      p = dx * cs + dy * sn;
      q = dy * cs - dx * sn;
      r.first  = POS_W'(clamp32((p + half) >>> 28));
      r.second = POS_W'(clamp32((q + half) >>> 28));
      ang = aa - bh;
    end
    r.angle = ang[ANG_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pose_result_t want;
    if (rst) begin
      expected_poses.delete();
      outstanding <= 0;
    end else begin
      if (done) begin
        if (expected_poses.size() == 0) begin
          report("result with no item pending");
        end else begin
          want = expected_poses.pop_front();
          if (res_first !== want.first)
            report($sformatf("res_first got %0d expected %0d", res_first, want.first));
          if (res_second !== want.second)
            report($sformatf("res_second got %0d expected %0d", res_second, want.second));
          if (res_angle !== want.angle)
            report($sformatf("res_angle got %h expected %h", res_angle, want.angle));
        end
      end
      if (start && !busy)
        expected_poses.push_back(compose_or_diff(command, longint'(base_x),
                                                 longint'(base_y), longint'(base_heading),
                                                 longint'(arg_first), longint'(arg_second),
                                                 longint'(arg_angle)));
      outstanding <= expected_poses.size();
    end
  end

endmodule

// ===== test/planar_pose_compose_and_difference_test.sv =====
// planar_pose_compose_and_difference_test: drives directed and random pose items
// into the block under several sender idling rates and gives the verdict
// depends on ppcd_pkg, planar_pose_compose_and_difference and planar_pose_checker
`timescale 1ns / 1ps

module planar_pose_compose_and_difference_test;
  import ppcd_pkg::*;

  localparam logic [HEAD_W-1:0] QUARTER_TURN = 21'd102944;
  localparam logic [HEAD_W-1:0] HALF_TURN    = 21'd205887;
  localparam logic [HEAD_W-1:0] FULL_TURN    = 21'd411775;
  localparam logic [HEAD_W-1:0] HEAD_MAX     = 21'h0FFFFF;
  localparam logic [HEAD_W-1:0] HEAD_MIN     = 21'h100000;
  localparam logic [POS_W-1:0]  POS_MAX      = 32'h7FFFFFFF;
  localparam logic [POS_W-1:0]  POS_MIN      = 32'h80000000;
  localparam logic [POS_W-1:0]  ONE_METER    = 32'h00010000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     command = CMD_COMPOSE;
  logic signed [POS_W-1:0]  base_x = '0;
  logic signed [POS_W-1:0]  base_y = '0;
  logic signed [HEAD_W-1:0] base_heading = '0;
  logic signed [POS_W-1:0]  arg_first = '0;
  logic signed [POS_W-1:0]  arg_second = '0;
  logic signed [HEAD_W-1:0] arg_angle = '0;
  logic                     done;
  logic signed [POS_W-1:0]  res_first;
  logic signed [POS_W-1:0]  res_second;
  logic signed [ANG_W-1:0]  res_angle;
  int                       failures;
  int                       outstanding;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  planar_pose_compose_and_difference DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .base_x(base_x), .base_y(base_y), .base_heading(base_heading),
    .arg_first(arg_first), .arg_second(arg_second), .arg_angle(arg_angle),
    .done(done), .res_first(res_first), .res_second(res_second), .res_angle(res_angle)
  );

  planar_pose_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .base_x(base_x), .base_y(base_y), .base_heading(base_heading),
    .arg_first(arg_first), .arg_second(arg_second), .arg_angle(arg_angle),
    .done(done), .res_first(res_first), .res_second(res_second), .res_angle(res_angle),
    .failures(failures), .outstanding(outstanding)
  );

  task automatic issue_pose(input logic cmd, input logic [POS_W-1:0] bx,
                            input logic [POS_W-1:0] by, input logic [HEAD_W-1:0] bh,
                            input logic [POS_W-1:0] a1, input logic [POS_W-1:0] a2,
                            input logic [HEAD_W-1:0] aa);
    @(negedge clk);
    start        <= 1'b1;
    command      <= cmd;
    base_x       <= bx;
    base_y       <= by;
    base_heading <= bh;
    arg_first    <= a1;
    arg_second   <= a2;
    arg_angle    <= aa;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (outstanding != 0 && n < 2000) begin
      @(negedge clk);
      n++;
    end
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h1FFFFF) - 32'h100000;
      2: begin
        v = $urandom_range(0, 255);
        v = $urandom_range(0, 1) ? POS_MAX - v : POS_MIN + v;
      end
      default: v = $urandom_range(0, 32'h7FFFFFF) - 32'h4000000;
    endcase
    return v;
  endfunction

  function automatic logic [HEAD_W-1:0] pick_heading();
    logic signed [31:0] h;
    case ($urandom_range(0, 3))
      0: h = $urandom;
      1: h = $signed($urandom_range(0, 823550)) - 411775;
      2: h = ($signed($urandom_range(0, 20)) - 10) * 102944
             + $signed($urandom_range(0, 16)) - 8;
      default: begin
        h = $urandom_range(0, 255);
        h = $urandom_range(0, 1) ? 32'sh000FFFFF - h : -32'sh00100000 + h;
      end
    endcase
    return h[HEAD_W-1:0];
  endfunction

  task automatic random_pose();
    logic              cmd;
    logic [POS_W-1:0]  bx, by, a1, a2;
    logic [HEAD_W-1:0] bh, aa;
    cmd = 1'($urandom_range(0, 1));
    bx  = pick_pos();
    by  = pick_pos();
    bh  = pick_heading();
    aa  = pick_heading();
    // targets near the base keep relative results mostly out of saturation
    if (cmd == CMD_RELATIVE && $urandom_range(0, 1)) begin
      a1 = bx + ($urandom_range(0, 32'h3FFFFF) - 32'h200000);
      a2 = by + ($urandom_range(0, 32'h3FFFFF) - 32'h200000);
    end else begin
      a1 = pick_pos();
      a2 = pick_pos();
    end
    issue_pose(cmd, bx, by, bh, a1, a2, aa);
  endtask

  initial begin
    int idle_pct [4];
    idle_pct = '{0, 85, 34, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed items, back to back
    issue_pose(CMD_COMPOSE, 0, 0, 0, 0, 0, 0);
    issue_pose(CMD_COMPOSE, ONE_METER, 0, 0, ONE_METER, 0, QUARTER_TURN);
    issue_pose(CMD_COMPOSE, 0, ONE_METER, QUARTER_TURN, ONE_METER, ONE_METER >> 1, 0);
    issue_pose(CMD_COMPOSE, 0, 0, -QUARTER_TURN, ONE_METER, -ONE_METER, 21'd5);
    issue_pose(CMD_COMPOSE, 0, 0, HALF_TURN, ONE_METER, ONE_METER, HALF_TURN);
    issue_pose(CMD_COMPOSE, 0, 0, HALF_TURN + 21'd1, ONE_METER, ONE_METER, 0);
    issue_pose(CMD_COMPOSE, POS_MAX, POS_MIN, HEAD_MAX, ONE_METER, ONE_METER, HEAD_MAX);
    issue_pose(CMD_COMPOSE, POS_MIN, POS_MAX, HEAD_MIN, ONE_METER, ONE_METER, HEAD_MIN);
    issue_pose(CMD_COMPOSE, POS_MAX, 0, 0, POS_MAX, 0, 0);
    issue_pose(CMD_COMPOSE, POS_MIN, 0, 0, POS_MIN, 0, 0);
    issue_pose(CMD_COMPOSE, 0, POS_MAX, 0, 0, POS_MAX, 0);
    issue_pose(CMD_COMPOSE, 0, POS_MIN, FULL_TURN, POS_MAX, POS_MIN, FULL_TURN);
    issue_pose(CMD_COMPOSE, POS_MAX, POS_MAX, QUARTER_TURN - 21'd1, POS_MAX, POS_MAX,
               -FULL_TURN);
    issue_pose(CMD_RELATIVE, 0, 0, 0, 0, 0, 0);
    issue_pose(CMD_RELATIVE, ONE_METER, ONE_METER, 0, 2 * ONE_METER, 2 * ONE_METER,
               QUARTER_TURN);
    issue_pose(CMD_RELATIVE, POS_MIN, 0, 0, POS_MAX, 0, 0);
    issue_pose(CMD_RELATIVE, POS_MAX, 0, 0, POS_MIN, 0, 0);
    issue_pose(CMD_RELATIVE, 0, POS_MIN, QUARTER_TURN, 0, POS_MAX, 0);
    issue_pose(CMD_RELATIVE, 0, 0, HEAD_MIN, ONE_METER, 0, HEAD_MAX);
    issue_pose(CMD_RELATIVE, 0, 0, HEAD_MAX, 0, ONE_METER, HEAD_MIN);
    issue_pose(CMD_RELATIVE, ONE_METER, -ONE_METER, -HALF_TURN, 0, 0, HALF_TURN);
    issue_pose(CMD_RELATIVE, POS_MAX, POS_MIN, -QUARTER_TURN, POS_MIN, POS_MAX, 0);

    // random items, one idling rate per phase, pipeline emptied in between
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 100; k++) begin
        while ($urandom_range(0, 99) < idle_pct[ph]) hold_off();
        random_pose();
      end
      hold_off();
      drain();
    end

    repeat (40) @(negedge clk);
    if (outstanding != 0) $display("results still missing: %0d", outstanding);
    if (failures == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
